[rtl/pngsw_pkg.sv]
package pngsw_pkg;

   localparam int unsigned CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] CSR_WIDTH  = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_HEIGHT = 1'd1;

   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;
   localparam logic [16:0] ADLER_MOD = 17'd65521;
   localparam logic [15:0] BLOCK_MAX = 16'hFFFF;
   localparam logic [31:0] TYPE_IHDR = 32'h49484452;
   localparam logic [31:0] TYPE_IDAT = 32'h49444154;
   localparam logic [31:0] TYPE_IEND = 32'h49454E44;
   localparam logic [5:0]  HDR_LAST  = 6'd42;
   localparam logic [4:0]  TAIL_LAST = 5'd19;
   localparam logic [2:0]  BLK_LAST  = 3'd4;
   localparam logic [2:0]  CALC_LAST = 3'd5;

   typedef enum logic [2:0] {
      SRC_CONST, SRC_WIDTH, SRC_HEIGHT, SRC_ZLEN,
      SRC_CRC, SRC_ADLER, SRC_BLOCK, SRC_DATA
   } src_type;

   typedef enum logic [1:0] {
      CRC_KEEP, CRC_FEED, CRC_INIT
   } crc_op_type;

   typedef enum logic [2:0] {
      CALC_NONE, CALC_LATCH, CALC_MUL, CALC_DIV1, CALC_DIV2, CALC_CORR, CALC_ZLEN
   } calc_type;

   typedef struct packed {
      logic       emit;
      src_type    src;
      logic [2:0] lane;
      logic [7:0] value;
      crc_op_type crc;
      logic       data_byte;
      logic       sample_byte;
      logic       blk_load;
      logic       run_last;
      logic       file_end;
   } byte_cmd_type;

   typedef struct packed {
      byte_cmd_type b;
      calc_type     calc;
      logic         take;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic row_start;
      logic blk_empty;
      logic blk_one;
      logic last_raw;
   } stat_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] v);
      logic [31:0] c;
      c = crc ^ {24'd0, v};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] sig_byte(input logic [2:0] k);
      logic [7:0] v;
      case (k)
         3'd0: v = 8'd137;
         3'd1: v = 8'd80;
         3'd2: v = 8'd78;
         3'd3: v = 8'd71;
         3'd4: v = 8'd13;
         3'd5: v = 8'd10;
         3'd6: v = 8'd26;
         default: v = 8'd10;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] type_byte(input logic [31:0] t, input logic [1:0] k);
      logic [1:0] lane;
      lane = 2'd3 - k;
      return t[{lane, 3'd0} +: 8];
   endfunction

   function automatic byte_cmd_type blank_cmd();
      byte_cmd_type c;
      c.emit        = 1'b0;
      c.src         = SRC_CONST;
      c.lane        = 3'd0;
      c.value       = 8'd0;
      c.crc         = CRC_KEEP;
      c.data_byte   = 1'b0;
      c.sample_byte = 1'b0;
      c.blk_load    = 1'b0;
      c.run_last    = 1'b0;
      c.file_end    = 1'b0;
      return c;
   endfunction

   // File header: signature, IHDR chunk, IDAT length and type, zlib header.
   function automatic byte_cmd_type hdr_cmd(input logic [5:0] idx);
      byte_cmd_type c;
      c = blank_cmd();
      if (idx < 6'd8) begin
         c.value = sig_byte(idx[2:0]);
      end else if (idx < 6'd12) begin
         c.value = (idx == 6'd11) ? 8'd13 : 8'd0;
      end else if (idx < 6'd16) begin
         c.value = type_byte(TYPE_IHDR, idx[1:0]);
         c.crc   = (idx == 6'd12) ? CRC_INIT : CRC_FEED;
      end else if (idx < 6'd20) begin
         c.src  = SRC_WIDTH;
         c.lane = 3'(6'd19 - idx);
         c.crc  = CRC_FEED;
      end else if (idx < 6'd24) begin
         c.src  = SRC_HEIGHT;
         c.lane = 3'(6'd23 - idx);
         c.crc  = CRC_FEED;
      end else if (idx < 6'd29) begin
         c.value = (idx == 6'd24) ? 8'd8 : ((idx == 6'd25) ? 8'd2 : 8'd0);
         c.crc   = CRC_FEED;
      end else if (idx < 6'd33) begin
         c.src  = SRC_CRC;
         c.lane = 3'(6'd32 - idx);
      end else if (idx < 6'd37) begin
         c.src  = SRC_ZLEN;
         c.lane = 3'(6'd36 - idx);
      end else if (idx < 6'd41) begin
         c.value = type_byte(TYPE_IDAT, 2'(idx - 6'd37));
         c.crc   = (idx == 6'd37) ? CRC_INIT : CRC_FEED;
      end else begin
         c.value = (idx == 6'd41) ? 8'h78 : 8'h01;
         c.crc   = CRC_FEED;
      end
      return c;
   endfunction

   // File trailer: Adler-32, IDAT CRC, IEND chunk.
   function automatic byte_cmd_type tail_cmd(input logic [4:0] idx);
      byte_cmd_type c;
      c = blank_cmd();
      if (idx < 5'd4) begin
         c.src  = SRC_ADLER;
         c.lane = 3'(5'd3 - idx);
         c.crc  = CRC_FEED;
      end else if (idx < 5'd8) begin
         c.src  = SRC_CRC;
         c.lane = 3'(5'd7 - idx);
      end else if (idx < 5'd12) begin
         c.value = 8'd0;
      end else if (idx < 5'd16) begin
         c.value = type_byte(TYPE_IEND, idx[1:0]);
         c.crc   = (idx == 5'd12) ? CRC_INIT : CRC_FEED;
      end else begin
         c.src      = SRC_CRC;
         c.lane     = 3'(5'd19 - idx);
         c.run_last = (idx == TAIL_LAST);
         c.file_end = (idx == TAIL_LAST);
      end
      return c;
   endfunction

endpackage

[rtl/pngsw_ctrl.sv]
module pngsw_ctrl
   import pngsw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  stat_type     stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_CALC = 7'b0000010,
      ST_HDR  = 7'b0000100,
      ST_BLK  = 7'b0001000,
      ST_FILT = 7'b0010000,
      ST_SAMP = 7'b0100000,
      ST_TAIL = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] idx_ff, idx_in;
   logic       in_file_ff, in_file_in;
   logic       filt_pend_ff, filt_pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         in_file_ff   <= 1'b0;
         filt_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         in_file_ff   <= in_file_in;
         filt_pend_ff <= filt_pend_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      in_file_in   = in_file_ff;
      filt_pend_in = filt_pend_ff;
      cmd.b        = blank_cmd();
      cmd.calc     = CALC_NONE;
      cmd.take     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               idx_in   = '0;
               if (!in_file_ff) begin
                  state_in = ST_CALC;
               end else begin
                  filt_pend_in = stat.row_start;
                  if (stat.blk_empty) begin
                     state_in = ST_BLK;
                  end else if (stat.row_start) begin
                     state_in = ST_FILT;
                  end else begin
                     state_in = ST_SAMP;
                  end
               end
            end
         end
         ST_CALC: begin
            case (idx_ff[2:0])
               3'd0: cmd.calc = CALC_LATCH;
               3'd1: cmd.calc = CALC_MUL;
               3'd2: cmd.calc = CALC_DIV1;
               3'd3: cmd.calc = CALC_DIV2;
               3'd4: cmd.calc = CALC_CORR;
               default: cmd.calc = CALC_ZLEN;
            endcase
            if (idx_ff[2:0] == CALC_LAST) begin
               state_in   = ST_HDR;
               idx_in     = '0;
               in_file_in = 1'b1;
            end else begin
               idx_in = idx_ff + 6'd1;
            end
         end
         ST_HDR: begin
            cmd.b      = hdr_cmd(idx_ff);
            cmd.b.emit = stat.out_free;
            if (stat.out_free) begin
               if (idx_ff == HDR_LAST) begin
                  state_in     = ST_BLK;
                  idx_in       = '0;
                  filt_pend_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 6'd1;
               end
            end
         end
         ST_BLK: begin
            cmd.b.emit     = stat.out_free;
            cmd.b.src      = SRC_BLOCK;
            cmd.b.lane     = idx_ff[2:0];
            cmd.b.crc      = CRC_FEED;
            cmd.b.blk_load = (idx_ff[2:0] == BLK_LAST);
            if (stat.out_free) begin
               if (idx_ff[2:0] == BLK_LAST) begin
                  idx_in   = '0;
                  state_in = filt_pend_ff ? ST_FILT : ST_SAMP;
               end else begin
                  idx_in = idx_ff + 6'd1;
               end
            end
         end
         ST_FILT: begin
            cmd.b.emit      = stat.out_free;
            cmd.b.crc       = CRC_FEED;
            cmd.b.data_byte = 1'b1;
            if (stat.out_free) begin
               filt_pend_in = 1'b0;
               idx_in       = '0;
               // The filter byte may close a block; the sample then opens a new one.
               state_in     = stat.blk_one ? ST_BLK : ST_SAMP;
            end
         end
         ST_SAMP: begin
            cmd.b.emit        = stat.out_free;
            cmd.b.src         = SRC_DATA;
            cmd.b.crc         = CRC_FEED;
            cmd.b.data_byte   = 1'b1;
            cmd.b.sample_byte = 1'b1;
            cmd.b.run_last    = !stat.last_raw;
            if (stat.out_free) begin
               idx_in   = '0;
               state_in = stat.last_raw ? ST_TAIL : ST_IDLE;
            end
         end
         ST_TAIL: begin
            cmd.b      = tail_cmd(idx_ff[4:0]);
            cmd.b.emit = stat.out_free;
            if (stat.out_free) begin
               if (idx_ff[4:0] == TAIL_LAST) begin
                  state_in   = ST_IDLE;
                  idx_in     = '0;
                  in_file_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 6'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/pngsw_datapath.sv]
module pngsw_datapath
   import pngsw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_sample,
   input  logic               csr_valid,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [15:0]        csr_wdata,
   input  ctrl_cmd_type       cmd,
   output stat_type           stat,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_run_last,
   output logic               rsp_file_end
);

   logic [15:0] width_ff, height_ff;
   logic [15:0] lat_w_ff, lat_w_in;
   logic [15:0] lat_h_ff, lat_h_in;
   logic [17:0] row_len_ff, row_len_in;
   logic [17:0] row_cnt_ff, row_cnt_in;
   logic [33:0] raw_rem_ff, raw_rem_in;
   logic [18:0] q_ff, q_in;
   logic [19:0] r_ff, r_in;
   logic [31:0] zlen_ff, zlen_in;
   logic [31:0] crc_ff, crc_in;
   logic [15:0] adl_lo_ff, adl_lo_in;
   logic [15:0] adl_hi_ff, adl_hi_in;
   logic [15:0] blk_fill_ff, blk_fill_in;
   logic [7:0]  sample_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff;
   logic        run_last_ff, file_end_ff;

   logic [34:0] div_x;
   logic [16:0] r2_sum;
   logic [15:0] blk_len;
   logic        blk_final;
   logic [31:0] word;
   logic [7:0]  cur_byte;
   logic [31:0] crc_base;
   logic [16:0] lo_sum, hi_sum;
   logic [15:0] lo_new;
   logic [17:0] row_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 16'd1;
         height_ff <= 16'd1;
      end else if (csr_valid) begin
         if (csr_index == CSR_WIDTH) begin
            width_ff <= csr_wdata;
         end
         if (csr_index == CSR_HEIGHT) begin
            height_ff <= csr_wdata;
         end
      end
   end

   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;
   assign stat.row_start = (row_cnt_ff == 18'd0);
   assign stat.blk_empty = (blk_fill_ff == 16'd0);
   assign stat.blk_one   = (blk_fill_ff == 16'd1);
   assign stat.last_raw  = (raw_rem_ff == 34'd1);

   assign blk_final = (raw_rem_ff <= {18'd0, BLOCK_MAX});
   assign blk_len   = blk_final ? raw_rem_ff[15:0] : BLOCK_MAX;
   assign div_x     = {1'b0, raw_rem_ff} + 35'd65534;
   assign r2_sum    = {1'b0, r_ff[15:0]} + {13'd0, r_ff[19:16]};

   always_comb begin
      case (cmd.b.src)
         SRC_WIDTH:  word = {16'd0, lat_w_ff};
         SRC_HEIGHT: word = {16'd0, lat_h_ff};
         SRC_ZLEN:   word = zlen_ff;
         SRC_CRC:    word = crc_ff ^ ALL_ONES;
         SRC_ADLER:  word = {adl_hi_ff, adl_lo_ff};
         default:    word = 32'd0;
      endcase
      case (cmd.b.src)
         SRC_CONST: cur_byte = cmd.b.value;
         SRC_DATA:  cur_byte = sample_ff;
         SRC_BLOCK: begin
            case (cmd.b.lane)
               3'd0: cur_byte = {7'd0, blk_final};
               3'd1: cur_byte = blk_len[7:0];
               3'd2: cur_byte = blk_len[15:8];
               3'd3: cur_byte = ~blk_len[7:0];
               default: cur_byte = ~blk_len[15:8];
            endcase
         end
         default: cur_byte = word[{cmd.b.lane[1:0], 3'd0} +: 8];
      endcase
   end

   // Adler sums stay below the modulus, so one subtraction reduces each add.
   always_comb begin
      lo_sum = {1'b0, adl_lo_ff} + {9'd0, cur_byte};
      lo_new = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
      hi_sum = {1'b0, adl_hi_ff} + {1'b0, lo_new};
   end

   assign crc_base = (cmd.b.crc == CRC_INIT) ? ALL_ONES : crc_ff;
   assign row_next = row_cnt_ff + 18'd1;

   always_comb begin
      lat_w_in     = lat_w_ff;
      lat_h_in     = lat_h_ff;
      row_len_in   = row_len_ff;
      row_cnt_in   = row_cnt_ff;
      raw_rem_in   = raw_rem_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      zlen_in      = zlen_ff;
      crc_in       = crc_ff;
      adl_lo_in    = adl_lo_ff;
      adl_hi_in    = adl_hi_ff;
      blk_fill_in  = blk_fill_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (cmd.calc)
         CALC_LATCH: begin
            lat_w_in    = (width_ff == 16'd0) ? 16'd1 : width_ff;
            lat_h_in    = (height_ff == 16'd0) ? 16'd1 : height_ff;
            row_cnt_in  = '0;
            adl_lo_in   = 16'd1;
            adl_hi_in   = 16'd0;
            blk_fill_in = '0;
         end
         CALC_MUL: begin
            row_len_in = {2'd0, lat_w_ff} + {1'b0, lat_w_ff, 1'b0};
            raw_rem_in = {18'd0, lat_h_ff} *
                         {16'd0, ({1'b0, lat_w_ff, 1'b0} + {2'd0, lat_w_ff} + 18'd1)};
         end
         CALC_DIV1: begin
            // Fold the count of 65535-byte blocks: 65536 * a + b = 65535 * a + (a + b).
            q_in = div_x[34:16];
            r_in = {4'd0, div_x[15:0]} + {1'b0, div_x[34:16]};
         end
         CALC_DIV2: begin
            q_in = q_ff + {15'd0, r_ff[19:16]};
            r_in = {3'd0, r2_sum};
         end
         CALC_CORR: begin
            if (r_ff >= 20'd65535) begin
               q_in = q_ff + 19'd1;
            end
         end
         CALC_ZLEN: begin
            zlen_in = raw_rem_ff[31:0] + 32'd6 + {11'd0, q_ff, 2'd0} + {13'd0, q_ff};
         end
         default: begin
         end
      endcase
      if (cmd.b.emit) begin
         rsp_valid_in = 1'b1;
         if (cmd.b.crc != CRC_KEEP) begin
            crc_in = crc_byte(crc_base, cur_byte);
         end
         if (cmd.b.blk_load) begin
            blk_fill_in = blk_len;
         end
         if (cmd.b.data_byte) begin
            adl_lo_in   = lo_new;
            adl_hi_in   = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
            blk_fill_in = blk_fill_ff - 16'd1;
            raw_rem_in  = raw_rem_ff - 34'd1;
         end
         if (cmd.b.sample_byte) begin
            row_cnt_in = (row_next >= row_len_ff) ? 18'd0 : row_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         lat_w_ff     <= 16'd1;
         lat_h_ff     <= 16'd1;
         row_cnt_ff   <= '0;
         raw_rem_ff   <= '0;
         crc_ff       <= ALL_ONES;
         adl_lo_ff    <= 16'd1;
         adl_hi_ff    <= 16'd0;
         blk_fill_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         lat_w_ff     <= lat_w_in;
         lat_h_ff     <= lat_h_in;
         row_cnt_ff   <= row_cnt_in;
         raw_rem_ff   <= raw_rem_in;
         crc_ff       <= crc_in;
         adl_lo_ff    <= adl_lo_in;
         adl_hi_ff    <= adl_hi_in;
         blk_fill_ff  <= blk_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      row_len_ff <= row_len_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      zlen_ff    <= zlen_in;
      if (cmd.take) begin
         sample_ff <= req_sample;
      end
      if (cmd.b.emit) begin
         out_byte_ff <= cur_byte;
         run_last_ff <= cmd.b.run_last;
         file_end_ff <= cmd.b.file_end;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = run_last_ff;
   assign rsp_file_end = file_end_ff;

endmodule

[rtl/png_stored_deflate_stream_writer.sv]
// Each item yields its run of output bytes, one byte per cycle while the output is not stalled.
// The first item of a file runs the setup steps for the stream length, then 50 bytes; a plain
// item takes 1 byte, plus 1 at a row start, 5 at a block start and 20 at the file end.
// The next item is taken in the cycle after the last byte of a run enters the output register.
// Reset (synchronous, active high) sets width and height to 1 and returns to start of file.
module png_stored_deflate_stream_writer
   import pngsw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_run_last,
   output logic               rsp_file_end,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [15:0]        csr_wdata
);

   ctrl_cmd_type cmd;
   stat_type     stat;

   assign csr_ready = 1'b1;

   pngsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pngsw_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_sample   (req_sample),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_file_end (rsp_file_end)
   );

endmodule
